FILE: design/luhn_check_digit_unit_top_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef LUHN_CHECK_DIGIT_UNIT_TOP_MACROS_SVH
`define LUHN_CHECK_DIGIT_UNIT_TOP_MACROS_SVH

// Property checked at every clock edge once reset is released.
`define LCD_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define LCD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/lcd_pkg.sv
package lcd_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_VERIFY = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [3:0]  DECIMAL_BASE = 4'd10;
    localparam logic [3:0]  MAX_DIGIT = 4'd9;

    // Word carried along the chain of digit cells.
    typedef struct packed {
        logic [31:0] rest;     // digits not yet consumed
        logic [31:0] payload;  // payload value, kept for the result
        logic [3:0]  sum;      // running digit sum, modulo ten
        logic [3:0]  last;     // received check digit for verify and remove
        logic        pre_ok;   // operation known and payload within range
        logic        is_add;
        logic        eos;
    } t_lane;

    // Exact floor(x / 10) for any 32-bit x by multiplying with the reciprocal.
    function automatic logic [31:0] div10(input logic [31:0] x);
        logic [63:0] prod;
        prod = {32'd0, x} * 64'h0000_0000_CCCC_CCCD;
        return {3'd0, prod[63:35]};
    endfunction

    function automatic logic [31:0] mul10(input logic [31:0] x);
        return (x << 3) + (x << 1);
    endfunction

endpackage

FILE: design/luhn_check_digit_unit_top.sv
// Channel  | Valid        | Ready        | Word fields
// ---------+--------------+--------------+---------------------------------------------
// input    | i_in_valid   | o_in_ready   | i_operation, i_value, i_end_of_series
// output   | o_out_valid  | i_out_ready  | o_result_value, o_ok, o_end_of_series_out
//
// One word is accepted per cycle unless the pipeline stalls; each word passes from
// acceptance to output through two front stages (divide by ten, range check), one digit
// cell per payload digit, and the output register that forms the check digit.
// Every stage has its own valid bit and stalls only when the stage after it is full.
// Synchronous active-low reset empties all stages; the block keeps no other state.
module luhn_check_digit_unit_top
    import lcd_pkg::*;
#(
    parameter int PAYLOAD_DIGITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_value,
    input  logic        i_end_of_series,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_result_value,
    output logic        o_ok,
    output logic        o_end_of_series_out
);

    localparam logic [31:0] LIMIT = 32'(10 ** PAYLOAD_DIGITS - 1);

    logic  chain_valid [0:PAYLOAD_DIGITS];
    logic  chain_ready [0:PAYLOAD_DIGITS];
    t_lane chain_lane  [0:PAYLOAD_DIGITS];

    lcd_front #(
        .LIMIT (LIMIT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_op    (i_operation),
        .i_value (i_value),
        .i_eos   (i_end_of_series),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_lane  (chain_lane[0])
    );

    // The lowest digit and every second digit above it are doubled.
    for (genvar g = 0; g < PAYLOAD_DIGITS; g++) begin : g_cell
        lcd_cell #(
            .DOUBLE_DIGIT ((g % 2 == 0) ? 1'b1 : 1'b0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_lane  (chain_lane[g]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_lane  (chain_lane[g+1])
        );
    end

    lcd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (chain_valid[PAYLOAD_DIGITS]),
        .o_ready  (chain_ready[PAYLOAD_DIGITS]),
        .i_lane   (chain_lane[PAYLOAD_DIGITS]),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (o_result_value),
        .o_ok     (o_ok),
        .o_eos    (o_end_of_series_out)
    );

endmodule

FILE: design/lcd_front.sv
module lcd_front
    import lcd_pkg::*;
#(
    parameter logic [31:0] LIMIT = 32'd99999999
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_value,
    input  logic        i_eos,
    output logic        o_valid,
    input  logic        i_ready,
    output t_lane       o_lane
);

    logic        r_a_valid;
    t_op         r_a_op;
    logic [31:0] r_a_value;
    logic [31:0] r_a_quot;
    logic        r_a_eos;
    logic        r_b_valid;
    t_lane       r_b_lane;
    t_lane       n_b_lane;
    logic        a_ready;
    logic        b_ready;
    logic [31:0] rem_full;
    logic        op_known;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // First stage: quotient by ten through the reciprocal multiplier.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_op    <= t_op'(i_op);
            r_a_value <= i_value;
            r_a_quot  <= div10(i_value);
            r_a_eos   <= i_eos;
        end
    end

    // Second stage: remainder, payload choice and range check.
    always_comb begin
        rem_full         = r_a_value - mul10(r_a_quot);
        n_b_lane         = '0;
        n_b_lane.last    = rem_full[3:0];
        n_b_lane.eos     = r_a_eos;
        n_b_lane.is_add  = 1'b0;
        op_known         = 1'b1;
        unique case (r_a_op)
            OP_ADD: begin
                n_b_lane.payload = r_a_value;
                n_b_lane.is_add  = 1'b1;
            end
            OP_VERIFY, OP_REMOVE: begin
                n_b_lane.payload = r_a_quot;
            end
            default: begin
                n_b_lane.payload = r_a_quot;
                op_known         = 1'b0;
            end
        endcase
        n_b_lane.rest   = n_b_lane.payload;
        n_b_lane.sum    = 4'd0;
        n_b_lane.pre_ok = op_known && (n_b_lane.payload <= LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_lane <= n_b_lane;
        end
    end

    assign o_valid = r_b_valid;
    assign o_lane  = r_b_lane;

endmodule

FILE: design/lcd_cell.sv
module lcd_cell
    import lcd_pkg::*;
#(
    parameter bit DOUBLE_DIGIT = 1'b1
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_lane i_lane,
    output logic  o_valid,
    input  logic  i_ready,
    output t_lane o_lane
);

    logic        r_valid;
    t_lane       r_lane;
    t_lane       n_lane;
    logic        ready;
    logic [31:0] quot;
    logic [31:0] rem_full;
    logic [3:0]  digit;
    logic [4:0]  twice;
    logic [3:0]  weighted;
    logic [4:0]  acc;

    assign ready   = !r_valid || i_ready;
    assign o_ready = ready;

    // Peel off the lowest decimal digit and fold it into the sum modulo ten.
    always_comb begin
        quot     = div10(i_lane.rest);
        rem_full = i_lane.rest - mul10(quot);
        digit    = rem_full[3:0];
        twice    = {digit, 1'b0};
        if (DOUBLE_DIGIT) begin
            if (twice > {1'b0, MAX_DIGIT}) begin
                weighted = 4'(twice - {1'b0, MAX_DIGIT});
            end else begin
                weighted = twice[3:0];
            end
        end else begin
            weighted = digit;
        end
        acc = {1'b0, i_lane.sum} + {1'b0, weighted};
        n_lane      = i_lane;
        n_lane.rest = quot;
        if (acc >= {1'b0, DECIMAL_BASE}) begin
            n_lane.sum = 4'(acc - {1'b0, DECIMAL_BASE});
        end else begin
            n_lane.sum = acc[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

FILE: design/lcd_back.sv
module lcd_back
    import lcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_lane       i_lane,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result,
    output logic        o_ok,
    output logic        o_eos
);

    logic        r_valid;
    logic [31:0] r_result;
    logic        r_ok;
    logic        r_eos;
    logic [31:0] n_result;
    logic        n_ok;
    logic        ready;
    logic [3:0]  check;

    assign ready   = !r_valid || i_ready;
    assign o_ready = ready;

    // (9 * sum) mod 10 is the ten's complement of the sum modulo ten.
    always_comb begin
        if (i_lane.sum == 4'd0) begin
            check = 4'd0;
        end else begin
            check = DECIMAL_BASE - i_lane.sum;
        end
        n_ok = i_lane.pre_ok && (i_lane.is_add || (check == i_lane.last));
        if (!n_ok) begin
            n_result = ALL_ONES;
        end else if (i_lane.is_add) begin
            n_result = mul10(i_lane.payload) + {28'd0, check};
        end else begin
            n_result = i_lane.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_result <= n_result;
            r_ok     <= n_ok;
            r_eos    <= i_lane.eos;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_ok     = r_ok;
    assign o_eos    = r_eos;

endmodule

FILE: design/lcd_checker.sv
`include "luhn_check_digit_unit_top_macros.svh"

module lcd_checker
    import lcd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_operation,
    input logic [31:0] i_value,
    input logic        i_end_of_series,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_result_value,
    input logic        o_ok,
    input logic        o_end_of_series_out
);

    // An offered input word stays put until the block takes it.
    `LCD_ASSERT_RUN(a_in_hold, i_clk, i_rst_n,
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_operation)
            && $stable(i_value) && $stable(i_end_of_series),
        "input word changed while waiting")

    // A word that is not taken stays offered and unchanged.
    `LCD_ASSERT_RUN(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_value)
            && $stable(o_ok) && $stable(o_end_of_series_out),
        "output word dropped or changed while stalled")

    // A failed word always carries the all-ones value.
    `LCD_ASSERT_RUN(a_fail_ones, i_clk, i_rst_n,
        o_out_valid && !o_ok |-> o_result_value == ALL_ONES,
        "failed word without all-ones value")

    // Reset empties the pipeline.
    `LCD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid,
        "output valid right after reset")

endmodule

bind luhn_check_digit_unit_top lcd_checker u_lcd_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_ready          (o_in_ready),
    .i_operation         (i_operation),
    .i_value             (i_value),
    .i_end_of_series     (i_end_of_series),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_result_value      (o_result_value),
    .o_ok                (o_ok),
    .o_end_of_series_out (o_end_of_series_out)
);
